@@ rtl/sih_pkg.sv @@
package sih_pkg;

    // Field widths of the request and response channels.
    localparam int OPCODE_W = 2;
    localparam int IDENT_W  = 10;
    localparam int LEN_W    = 7;
    localparam int STATUS_W = 3;

    // Default capacities.
    localparam int SLOTS_DEF        = 1024;
    localparam int MAX_ENTRIES_DEF  = 512;
    localparam int ARENA_BYTES_DEF  = 4096;
    localparam int MAX_NAME_LEN_DEF = 64;

    // FNV-1a 64-bit constants. The prime is 2**40 + 435.
    localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
    localparam logic [63:0] FNV_LOW   = 64'd435;

    typedef enum logic [OPCODE_W-1:0] {
        OP_FIND   = 2'd0,
        OP_INTERN = 2'd1,
        OP_READ   = 2'd2,
        OP_BAD    = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_INVALID  = 3'd1,
        ST_FULL     = 3'd2,
        ST_TOO_LONG = 3'd3,
        ST_BAD_ID   = 3'd4
    } status_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [IDENT_W-1:0]  identifier;
        logic [7:0]          name_byte;
        logic                kind;
        logic [LEN_W-1:0]    name_length;
        logic                last;
    } result_t;

    // One FNV-1a step: xor in a byte, multiply by the prime as shift plus small product.
    function automatic logic [63:0] fnv_mix(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + x * FNV_LOW;
    endfunction

    localparam logic [63:0] FNV_KIND0 = fnv_mix(FNV_BASIS, 8'd0);
    localparam logic [63:0] FNV_KIND1 = fnv_mix(FNV_BASIS, 8'd1);

    function automatic result_t mk_result(input status_t st, input logic fnd,
                                          input logic [IDENT_W-1:0] id,
                                          input logic [7:0] b, input logic knd,
                                          input logic [LEN_W-1:0] len,
                                          input logic lst);
        result_t r;
        r.status      = st;
        r.found       = fnd;
        r.identifier  = id;
        r.name_byte   = b;
        r.kind        = knd;
        r.name_length = len;
        r.last        = lst;
        return r;
    endfunction

endpackage

@@ rtl/sih_req_if.sv @@
interface sih_req_if
    import sih_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic                kind;
    logic                has_byte;
    logic [7:0]          data_byte;
    logic                last;
    logic [IDENT_W-1:0]  identifier_in;

    modport source (output valid, opcode, kind, has_byte, data_byte, last, identifier_in,
                    input ready);
    modport sink   (input valid, opcode, kind, has_byte, data_byte, last, identifier_in,
                    output ready);
endinterface

@@ rtl/sih_rsp_if.sv @@
interface sih_rsp_if
    import sih_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [IDENT_W-1:0]  identifier_out;
    logic [7:0]          name_byte;
    logic                kind_out;
    logic [LEN_W-1:0]    name_length;
    logic                last_out;

    modport source (output valid, status, found, identifier_out, name_byte, kind_out,
                    name_length, last_out, input ready);
    modport sink   (input valid, status, found, identifier_out, name_byte, kind_out,
                    name_length, last_out, output ready);
endinterface

@@ rtl/sih_ram.sv @@
module sih_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/symbol_intern_hash_table.sv @@
// Symbol intern table. Name bytes arrive one request each and are hashed on the fly
// (64-bit FNV-1a, one step per byte in the accepting cycle), so a byte that does not
// end a name is finished in that cycle. The request marked last finalises the hash
// over the length and then probes the slot table linearly: an empty slot takes the
// steps address and slot read, an occupied one address, slot read and entry read,
// and a slot whose stored hash, kind and length agree adds a read and a compare per
// name byte against the arena. A miss is then decided; an intern of a new name
// copies it into the arena with a read and a write per byte and links it, and the
// response then moves into the output register once that register is free.
// A read fetches the entry and replays the stored name, a read and an output step
// per byte, each byte waiting for a free output register. Tables sit in synchronous
// read RAMs, and one request is worked on at a time. After reset the slot table is
// cleared one slot per cycle, during which no request is accepted. A finished
// response waits in an output register.
module symbol_intern_hash_table
    import sih_pkg::*;
#(
    parameter int SLOTS        = SLOTS_DEF,
    parameter int MAX_ENTRIES  = MAX_ENTRIES_DEF,
    parameter int ARENA_BYTES  = ARENA_BYTES_DEF,
    parameter int MAX_NAME_LEN = MAX_NAME_LEN_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    sih_req_if.sink   req,
    sih_rsp_if.source rsp
);
    localparam int SW   = $clog2(SLOTS);
    localparam int IW   = $clog2(MAX_ENTRIES + 1);
    localparam int EW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int AW   = $clog2(ARENA_BYTES);
    localparam int PW   = (MAX_NAME_LEN > 1) ? $clog2(MAX_NAME_LEN) : 1;
    localparam int EDW  = 64 + AW + LEN_W + 1;

    typedef enum logic [15:0] {
        S_IDLE     = 16'b0000_0000_0000_0001,
        S_CLEAR    = 16'b0000_0000_0000_0010,
        S_FIN      = 16'b0000_0000_0000_0100,
        S_SLOT_RD  = 16'b0000_0000_0000_1000,
        S_SLOT_CHK = 16'b0000_0000_0001_0000,
        S_ENT_CHK  = 16'b0000_0000_0010_0000,
        S_CMP_RD   = 16'b0000_0000_0100_0000,
        S_CMP_CHK  = 16'b0000_0000_1000_0000,
        S_MISS     = 16'b0000_0001_0000_0000,
        S_CPY_RD   = 16'b0000_0010_0000_0000,
        S_CPY_WR   = 16'b0000_0100_0000_0000,
        S_LINK     = 16'b0000_1000_0000_0000,
        S_RD_ENT   = 16'b0001_0000_0000_0000,
        S_RD_BYTE  = 16'b0010_0000_0000_0000,
        S_RD_OUT   = 16'b0100_0000_0000_0000,
        S_EMIT     = 16'b1000_0000_0000_0000
    } state_t;

    state_t           state_reg, state_next;
    logic [SW-1:0]    clr_reg, clr_next;
    logic [LEN_W-1:0] pend_len_reg, pend_len_next;
    logic [63:0]      h0_reg, h0_next, h1_reg, h1_next;
    logic [63:0]      hash_reg, hash_next;
    logic             intern_reg, intern_next;
    logic             kind_reg, kind_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [SW-1:0]    slot_reg, slot_next;
    logic [SW:0]      pcnt_reg, pcnt_next;
    logic [IW-1:0]    cand_reg, cand_next;
    logic [AW-1:0]    off_reg, off_next;
    logic [LEN_W-1:0] idx_reg, idx_next;
    logic [IW-1:0]    count_reg, count_next;
    logic [AW:0]      fill_reg, fill_next;
    logic [SW-1:0]    empty_reg, empty_next;
    logic             empty_ok_reg, empty_ok_next;
    logic [IDENT_W-1:0] rid_reg, rid_next;
    result_t          res_reg, res_next;
    result_t          out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    // RAM ports.
    logic             slot_we;
    logic [SW-1:0]    slot_waddr;
    logic [IW-1:0]    slot_wdata, slot_rdata;
    logic             ent_we;
    logic [EW-1:0]    ent_waddr, ent_raddr;
    logic [EDW-1:0]   ent_wdata, ent_rdata;
    logic             arena_we;
    logic [AW-1:0]    arena_waddr, arena_raddr;
    logic [7:0]       arena_rdata;
    logic             pend_we;
    logic [PW-1:0]    pend_waddr;
    logic [7:0]       pend_rdata;

    logic             out_free;
    logic             req_fire;
    logic [LEN_W-1:0] nlen;
    logic             take_byte;
    logic [63:0]      e_hash;
    logic [AW-1:0]    e_off;
    logic [LEN_W-1:0] e_len;
    logic             e_kind;
    logic             e_match;
    logic             last_idx;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign req_fire  = req.valid && req.ready;

    assign {e_hash, e_off, e_len, e_kind} = ent_rdata;
    assign e_match = (e_hash == hash_reg) && (e_kind == kind_reg) && (e_len == len_reg)
                     && (({1'b0, e_off} + (AW+1)'(e_len)) <= (AW+1)'(ARENA_BYTES));
    assign last_idx = (idx_reg == len_reg - LEN_W'(1));

    // A byte is kept only while the pending name still has room; the count saturates
    // one above the limit so that an overlong name is recognised.
    assign take_byte = req.has_byte && (pend_len_reg < LEN_W'(MAX_NAME_LEN));
    assign nlen = (req.has_byte && (pend_len_reg <= LEN_W'(MAX_NAME_LEN)))
                  ? pend_len_reg + LEN_W'(1) : pend_len_reg;

    assign arena_raddr = off_reg + AW'(idx_reg);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        pend_len_next  = pend_len_reg;
        h0_next        = h0_reg;
        h1_next        = h1_reg;
        hash_next      = hash_reg;
        intern_next    = intern_reg;
        kind_next      = kind_reg;
        len_next       = len_reg;
        slot_next      = slot_reg;
        pcnt_next      = pcnt_reg;
        cand_next      = cand_reg;
        off_next       = off_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        fill_next      = fill_reg;
        empty_next     = empty_reg;
        empty_ok_next  = empty_ok_reg;
        rid_next       = rid_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp.ready;

        slot_we     = 1'b0;
        slot_waddr  = slot_reg;
        slot_wdata  = '0;
        ent_we      = 1'b0;
        ent_waddr   = EW'(count_reg);
        ent_wdata   = {hash_reg, fill_reg[AW-1:0], len_reg, kind_reg};
        ent_raddr   = '0;
        arena_we    = 1'b0;
        arena_waddr = fill_reg[AW-1:0] + AW'(idx_reg);
        pend_we     = 1'b0;
        pend_waddr  = PW'(pend_len_reg);

        unique case (state_reg)
            S_CLEAR:
            begin
                slot_we    = 1'b1;
                slot_waddr = clr_reg;
                clr_next   = clr_reg + SW'(1);
                if (clr_reg == SW'(SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req_fire)
                begin
                    unique case (opcode_t'(req.opcode))
                        OP_BAD:
                        begin
                            pend_len_next  = '0;
                            h0_next        = FNV_KIND0;
                            h1_next        = FNV_KIND1;
                            out_next       = mk_result(ST_INVALID, 1'b0, '0, '0, 1'b0, '0, 1'b1);
                            out_valid_next = 1'b1;
                        end
                        OP_READ:
                        begin
                            if ((req.identifier_in == '0)
                                || (32'(req.identifier_in) > 32'(count_reg)))
                            begin
                                out_next = mk_result(ST_BAD_ID, 1'b0, '0, '0, 1'b0, '0, 1'b1);
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                ent_raddr  = EW'(req.identifier_in - IDENT_W'(1));
                                rid_next   = req.identifier_in;
                                state_next = S_RD_ENT;
                            end
                        end
                        OP_FIND, OP_INTERN:
                        begin
                            pend_we = take_byte;
                            if (take_byte)
                            begin
                                h0_next = fnv_mix(h0_reg, req.data_byte);
                                h1_next = fnv_mix(h1_reg, req.data_byte);
                            end
                            if (req.last)
                            begin
                                pend_len_next = '0;
                                h0_next       = FNV_KIND0;
                                h1_next       = FNV_KIND1;
                                if (nlen > LEN_W'(MAX_NAME_LEN))
                                begin
                                    out_next = mk_result(ST_TOO_LONG, 1'b0, '0, '0, 1'b0, '0,
                                                         1'b1);
                                    out_valid_next = 1'b1;
                                end
                                else if (req.kind && (nlen != LEN_W'(1)))
                                begin
                                    out_next = mk_result(ST_INVALID, 1'b0, '0, '0, 1'b0, '0,
                                                         1'b1);
                                    out_valid_next = 1'b1;
                                end
                                else
                                begin
                                    if (take_byte)
                                    begin
                                        hash_next = req.kind ? fnv_mix(h1_reg, req.data_byte)
                                                             : fnv_mix(h0_reg, req.data_byte);
                                    end
                                    else
                                    begin
                                        hash_next = req.kind ? h1_reg : h0_reg;
                                    end
                                    len_next    = nlen;
                                    kind_next   = req.kind;
                                    intern_next = (opcode_t'(req.opcode) == OP_INTERN);
                                    state_next  = S_FIN;
                                end
                            end
                            else
                            begin
                                pend_len_next = nlen;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_FIN:
            begin
                hash_next  = fnv_mix(hash_reg, {1'b0, len_reg});
                slot_next  = fnv_mix(hash_reg, {1'b0, len_reg})[SW-1:0];
                pcnt_next  = '0;
                state_next = S_SLOT_RD;
            end

            S_SLOT_RD:
            begin
                state_next = S_SLOT_CHK;
            end

            S_SLOT_CHK:
            begin
                if (slot_rdata == '0)
                begin
                    empty_next    = slot_reg;
                    empty_ok_next = 1'b1;
                    state_next    = S_MISS;
                end
                else
                begin
                    ent_raddr  = EW'(slot_rdata - IW'(1));
                    cand_next  = slot_rdata;
                    state_next = S_ENT_CHK;
                end
            end

            S_ENT_CHK, S_CMP_CHK:
            begin
                if ((state_reg == S_ENT_CHK) ? !e_match : (arena_rdata != pend_rdata))
                begin
                    // Next slot, unless the whole table has been probed.
                    slot_next = slot_reg + SW'(1);
                    pcnt_next = pcnt_reg + (SW+1)'(1);
                    if (pcnt_reg == (SW+1)'(SLOTS - 1))
                    begin
                        empty_ok_next = 1'b0;
                        state_next    = S_MISS;
                    end
                    else
                    begin
                        state_next = S_SLOT_RD;
                    end
                end
                else if ((state_reg == S_ENT_CHK) && (len_reg != '0))
                begin
                    off_next   = e_off;
                    idx_next   = '0;
                    state_next = S_CMP_RD;
                end
                else if ((state_reg == S_CMP_CHK) && !last_idx)
                begin
                    idx_next   = idx_reg + LEN_W'(1);
                    state_next = S_CMP_RD;
                end
                else
                begin
                    res_next   = mk_result(ST_OK, 1'b1, IDENT_W'(cand_reg), '0, 1'b0, '0, 1'b1);
                    state_next = S_EMIT;
                end
            end

            S_CMP_RD:
            begin
                state_next = S_CMP_CHK;
            end

            S_MISS:
            begin
                if (!intern_reg)
                begin
                    res_next   = mk_result(ST_OK, 1'b0, '0, '0, 1'b0, '0, 1'b1);
                    state_next = S_EMIT;
                end
                else if (!empty_ok_reg || (32'(count_reg) >= 32'(MAX_ENTRIES))
                         || (({1'b0, fill_reg} + (AW+2)'(len_reg)) > (AW+2)'(ARENA_BYTES)))
                begin
                    res_next   = mk_result(ST_FULL, 1'b0, '0, '0, 1'b0, '0, 1'b1);
                    state_next = S_EMIT;
                end
                else
                begin
                    ent_we     = 1'b1;
                    idx_next   = '0;
                    state_next = (len_reg == '0) ? S_LINK : S_CPY_RD;
                end
            end

            S_CPY_RD:
            begin
                state_next = S_CPY_WR;
            end

            S_CPY_WR:
            begin
                arena_we = 1'b1;
                if (last_idx)
                begin
                    state_next = S_LINK;
                end
                else
                begin
                    idx_next   = idx_reg + LEN_W'(1);
                    state_next = S_CPY_RD;
                end
            end

            S_LINK:
            begin
                slot_we    = 1'b1;
                slot_waddr = empty_reg;
                slot_wdata = count_reg + IW'(1);
                count_next = count_reg + IW'(1);
                fill_next  = fill_reg + (AW+1)'(len_reg);
                res_next   = mk_result(ST_OK, 1'b0, IDENT_W'(count_reg + IW'(1)), '0, 1'b0, '0,
                                       1'b1);
                state_next = S_EMIT;
            end

            S_RD_ENT:
            begin
                off_next  = e_off;
                len_next  = e_len;
                kind_next = e_kind;
                idx_next  = '0;
                if (e_len == '0)
                begin
                    res_next   = mk_result(ST_OK, 1'b1, rid_reg, '0, e_kind, '0, 1'b1);
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_RD_BYTE;
                end
            end

            S_RD_BYTE:
            begin
                state_next = S_RD_OUT;
            end

            S_RD_OUT:
            begin
                if (out_free)
                begin
                    out_next = mk_result(ST_OK, 1'b1, rid_reg, arena_rdata, kind_reg, len_reg,
                                         last_idx);
                    out_valid_next = 1'b1;
                    if (last_idx)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + LEN_W'(1);
                        state_next = S_RD_BYTE;
                    end
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            pend_len_reg  <= '0;
            h0_reg        <= FNV_KIND0;
            h1_reg        <= FNV_KIND1;
            count_reg     <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pend_len_reg  <= pend_len_next;
            h0_reg        <= h0_next;
            h1_reg        <= h1_next;
            count_reg     <= count_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hash_reg     <= hash_next;
        intern_reg   <= intern_next;
        kind_reg     <= kind_next;
        len_reg      <= len_next;
        slot_reg     <= slot_next;
        pcnt_reg     <= pcnt_next;
        cand_reg     <= cand_next;
        off_reg      <= off_next;
        idx_reg      <= idx_next;
        empty_reg    <= empty_next;
        empty_ok_reg <= empty_ok_next;
        rid_reg      <= rid_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

    // Slot table: identifier (entry index plus one) per slot, zero when empty.
    sih_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_reg),
        .rdata (slot_rdata)
    );

    // Entry records: hash, arena offset, length and kind.
    sih_ram #(.WIDTH(EDW), .DEPTH(MAX_ENTRIES)) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    sih_ram #(.WIDTH(8), .DEPTH(ARENA_BYTES)) u_arena_ram (
        .clk   (clk),
        .we    (arena_we),
        .waddr (arena_waddr),
        .wdata (pend_rdata),
        .raddr (arena_raddr),
        .rdata (arena_rdata)
    );

    // Bytes of the name still being gathered.
    sih_ram #(.WIDTH(8), .DEPTH(MAX_NAME_LEN)) u_pend_ram (
        .clk   (clk),
        .we    (pend_we),
        .waddr (pend_waddr),
        .wdata (req.data_byte),
        .raddr (PW'(idx_reg)),
        .rdata (pend_rdata)
    );

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_reg.status;
    assign rsp.found          = out_reg.found;
    assign rsp.identifier_out = out_reg.identifier;
    assign rsp.name_byte      = out_reg.name_byte;
    assign rsp.kind_out       = out_reg.kind;
    assign rsp.name_length    = out_reg.name_length;
    assign rsp.last_out       = out_reg.last;
endmodule

@@ rtl/sih_checker.sv @@
module sih_checker
    import sih_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input logic [STATUS_W-1:0] status,
    input logic                found,
    input logic [IDENT_W-1:0]  identifier,
    input logic [7:0]          name_byte,
    input logic                last
);
    // A stalled response stays offered.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(identifier))
        else $error("response withdrawn while stalled");

    // Any error ends its run at once and names no identifier.
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> !found && (identifier == '0) && last)
        else $error("error response carries identifier or continues");

    // A found name or a replayed byte always comes with a real identifier.
    a_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> (identifier != '0) && (status == ST_OK))
        else $error("found without identifier");

    // Name bytes appear only in a replay.
    a_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (name_byte != '0) |-> found)
        else $error("name byte outside a replay");
endmodule

bind symbol_intern_hash_table sih_checker u_sih_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .status     (rsp.status),
    .found      (rsp.found),
    .identifier (rsp.identifier_out),
    .name_byte  (rsp.name_byte),
    .last       (rsp.last_out)
);

@@ sim/symbol_intern_hash_table_tb.sv @@
`timescale 1ns / 100ps

// Self-checking bench for the symbol intern table. Every request that the
// block accepts is fed through a behavioural copy of the table kept here,
// which works out the responses that the request must cause; the monitor then
// checks every response against the oldest of them, field by field.
module symbol_intern_hash_table_tb;
    import sih_pkg::*;

    localparam int          N_SLOTS    = 1024;
    localparam int          N_ENTRIES  = 512;
    localparam int          N_ARENA    = 4096;
    localparam int          NAME_MAX   = 64;
    localparam bit [63:0]   HASH_PRIME = 64'd1099511628211;
    localparam bit [63:0]   HASH_SEED  = 64'd14695981039346656037;
    localparam int          CYCLE_CAP  = 600000;

    // One request as it is put on the request channel.
    typedef struct {
        opcode_t    op;
        bit         kind;
        bit         has_byte;
        bit [7:0]   data;
        bit         last;
        bit [9:0]   ident;
    } name_req_t;

    logic clk;
    logic rst_n = 1'b0;

    sih_req_if req ();
    sih_rsp_if rsp ();

    symbol_intern_hash_table i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // Requests waiting to be driven, and responses the table copy expects.
    name_req_t request_q[$];
    result_t   response_q[$];

    int  idle_pct     = 14;
    bit  send_hold    = 1'b0;
    int  fail_count   = 0;
    int  checked      = 0;
    int  interned     = 0;
    int  reads_ok     = 0;
    int  hits         = 0;
    int  cycle_count  = 0;
    name_req_t cur;

    // Behavioural copy of the table state.
    bit [9:0]  tbl_slot [N_SLOTS];
    bit [63:0] tbl_hash [N_ENTRIES];
    bit [11:0] tbl_off  [N_ENTRIES];
    bit [6:0]  tbl_len  [N_ENTRIES];
    bit        tbl_kind [N_ENTRIES];
    bit [7:0]  tbl_arena[N_ARENA];
    bit [7:0]  name_buf [NAME_MAX];
    int        tbl_count  = 0;
    int        arena_used = 0;
    int        name_len   = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        req.valid = 1'b0;
        req.opcode = OP_FIND;
        req.kind = 1'b0;
        req.has_byte = 1'b0;
        req.data_byte = 8'd0;
        req.last = 1'b0;
        req.identifier_in = '0;
        rsp.ready = 1'b0;
        foreach (tbl_slot[i])
            tbl_slot[i] = '0;
    end

    function automatic result_t make_response(status_t st, bit fnd, bit [9:0] id,
                                              bit [7:0] b, bit knd, bit [6:0] len);
        result_t r;
        r.status      = st;
        r.found       = fnd;
        r.identifier  = id;
        r.name_byte   = b;
        r.kind        = knd;
        r.name_length = len;
        r.last        = 1'b1;
        return r;
    endfunction

    // FNV-1a over the kind, the buffered bytes and finally the length.
    function automatic bit [63:0] name_digest(bit knd, int len);
        bit [63:0] h;
        h = (HASH_SEED ^ 64'(knd)) * HASH_PRIME;
        for (int i = 0; i < len; i++)
            h = (h ^ 64'(name_buf[i])) * HASH_PRIME;
        h = (h ^ 64'(len)) * HASH_PRIME;
        return h;
    endfunction

    // Linear probe from the home slot. Returns the matching identifier or 0;
    // free_slot gets the first empty slot met, or N_SLOTS if there was none.
    function automatic int find_entry(bit [63:0] h, bit knd, int len, output int free_slot);
        int  slot;
        int  e;
        bit  same;
        slot = int'(h % N_SLOTS);
        free_slot = N_SLOTS;
        for (int n = 0; n < N_SLOTS; n++)
        begin
            if (tbl_slot[slot] == 0)
            begin
                free_slot = slot;
                return 0;
            end
            e = int'(tbl_slot[slot]) - 1;
            if (tbl_hash[e] == h && tbl_kind[e] == knd && tbl_len[e] == len)
            begin
                same = 1'b1;
                for (int i = 0; i < len; i++)
                    if (tbl_arena[tbl_off[e] + i] != name_buf[i])
                        same = 1'b0;
                if (same)
                    return int'(tbl_slot[slot]);
            end
            slot = (slot + 1) % N_SLOTS;
        end
        return 0;
    endfunction

    // Applies one accepted request to the table copy and queues its responses.
    task automatic intern_predict(name_req_t r);
        int        len;
        int        id;
        int        free_slot;
        int        e;
        bit [63:0] h;
        result_t   x;
        if (r.op == OP_BAD)
        begin
            name_len = 0;
            response_q.push_back(make_response(ST_INVALID, 0, 0, 0, 0, 0));
            return;
        end
        if (r.op == OP_READ)
        begin
            if (r.ident == 0 || r.ident > tbl_count)
            begin
                response_q.push_back(make_response(ST_BAD_ID, 0, 0, 0, 0, 0));
                return;
            end
            e = r.ident - 1;
            reads_ok++;
            if (tbl_len[e] == 0)
            begin
                response_q.push_back(make_response(ST_OK, 1, r.ident, 0, tbl_kind[e], 0));
                return;
            end
            for (int i = 0; i < tbl_len[e]; i++)
            begin
                x = make_response(ST_OK, 1, r.ident, tbl_arena[tbl_off[e] + i],
                                  tbl_kind[e], tbl_len[e]);
                x.last = (i + 1 == tbl_len[e]);
                response_q.push_back(x);
            end
            return;
        end
        if (r.has_byte)
        begin
            if (name_len < NAME_MAX)
                name_buf[name_len] = r.data;
            if (name_len <= NAME_MAX)
                name_len++;
        end
        if (!r.last)
            return;
        len = name_len;
        name_len = 0;
        if (len > NAME_MAX)
        begin
            response_q.push_back(make_response(ST_TOO_LONG, 0, 0, 0, 0, 0));
            return;
        end
        if (r.kind && len != 1)
        begin
            response_q.push_back(make_response(ST_INVALID, 0, 0, 0, 0, 0));
            return;
        end
        h = name_digest(r.kind, len);
        id = find_entry(h, r.kind, len, free_slot);
        if (id != 0)
        begin
            hits++;
            response_q.push_back(make_response(ST_OK, 1, 10'(id), 0, 0, 0));
            return;
        end
        if (r.op == OP_FIND)
        begin
            response_q.push_back(make_response(ST_OK, 0, 0, 0, 0, 0));
            return;
        end
        if (tbl_count >= N_ENTRIES || free_slot >= N_SLOTS || arena_used + len > N_ARENA)
        begin
            response_q.push_back(make_response(ST_FULL, 0, 0, 0, 0, 0));
            return;
        end
        tbl_hash[tbl_count] = h;
        tbl_off[tbl_count]  = 12'(arena_used);
        tbl_len[tbl_count]  = 7'(len);
        tbl_kind[tbl_count] = r.kind;
        for (int i = 0; i < len; i++)
            tbl_arena[arena_used + i] = name_buf[i];
        arena_used += len;
        tbl_count++;
        tbl_slot[free_slot] = 10'(tbl_count);
        interned++;
        response_q.push_back(make_response(ST_OK, 0, 10'(tbl_count), 0, 0, 0));
    endtask

    task automatic report(string what, int want, int got);
        $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
        fail_count++;
    endtask

    // Request driver. A new request is loaded only when the channel is free or
    // the current request is being taken at this edge, so valid never drops
    // and rises within the same step.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
        end
        else
        begin
            if (req.valid && req.ready)
                intern_predict(cur);
            if (!req.valid || req.ready)
            begin
                if (request_q.size() > 0 && !send_hold &&
                    $urandom_range(0, 99) >= idle_pct)
                begin
                    cur = request_q.pop_front();
                    req.valid         <= 1'b1;
                    req.opcode        <= cur.op;
                    req.kind          <= cur.kind;
                    req.has_byte      <= cur.has_byte;
                    req.data_byte     <= cur.data;
                    req.last          <= cur.last;
                    req.identifier_in <= cur.ident;
                end
                else
                begin
                    req.valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor with random back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
        end
        else
        begin
            cycle_count++;
            rsp.ready <= ($urandom_range(0, 99) >= idle_pct);
            if (rsp.valid && rsp.ready)
            begin
                checked++;
                if (response_q.size() == 0)
                begin
                    $display("[%0t] response arrived with none expected", $realtime);
                    fail_count++;
                end
                else
                begin
                    want = response_q.pop_front();
                    if (rsp.status != want.status)
                        report("status", want.status, rsp.status);
                    if (rsp.found != want.found)
                        report("found", want.found, rsp.found);
                    if (rsp.identifier_out != want.identifier)
                        report("identifier_out", want.identifier, rsp.identifier_out);
                    if (rsp.name_byte != want.name_byte)
                        report("name_byte", want.name_byte, rsp.name_byte);
                    if (rsp.kind_out != want.kind)
                        report("kind_out", want.kind, rsp.kind_out);
                    if (rsp.name_length != want.name_length)
                        report("name_length", want.name_length, rsp.name_length);
                    if (rsp.last_out != want.last)
                        report("last_out", want.last, rsp.last_out);
                end
            end
        end
    end

    // Watchdog: the slowest legal run stays far below this.
    always @(posedge clk)
    begin
        if (cycle_count > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, response_q.size());
            $display("symbol_intern_hash_table regression: fail");
            $finish;
        end
    end

    task automatic push_req(opcode_t op, bit knd, bit hb, bit [7:0] b, bit lst, bit [9:0] id);
        name_req_t r;
        r.op = op;
        r.kind = knd;
        r.has_byte = hb;
        r.data = b;
        r.last = lst;
        r.ident = id;
        request_q.push_back(r);
    endtask

    // Sends a whole name. An empty name is one request carrying no byte. The
    // kind only matters on the closing request, so the earlier ones get noise.
    task automatic push_name(opcode_t op, bit knd, bit [7:0] nm[$]);
        if (nm.size() == 0)
        begin
            push_req(op, knd, 1'b0, 8'($urandom), 1'b1, 10'($urandom));
            return;
        end
        for (int i = 0; i < nm.size(); i++)
            push_req(op, (i + 1 == nm.size()) ? knd : 1'($urandom), 1'b1, nm[i],
                     i + 1 == nm.size(), 10'($urandom));
    endtask

    task automatic push_read(bit [9:0] id);
        push_req(OP_READ, 1'($urandom), 1'($urandom), 8'($urandom), 1'($urandom), id);
    endtask

    task automatic wait_drained();
        while (request_q.size() > 0 || req.valid || response_q.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        bit [7:0] nm[$];
        bit [7:0] pool[4];
        int       sent;
        int       len;
        int       pick;
        opcode_t  op;
        bit       knd;

        // Directed part: empty names, byte extremes, active names, bad codes,
        // reads in and out of range, a name at the length limit and one past it.
        nm = {};
        push_name(OP_FIND, 1'b0, nm);           // empty table, not found
        push_name(OP_INTERN, 1'b0, nm);         // empty name becomes entry 1
        push_name(OP_FIND, 1'b0, nm);
        push_read(10'd1);                       // empty stored name
        nm = {8'h00, 8'hFF};
        push_name(OP_INTERN, 1'b0, nm);
        push_name(OP_INTERN, 1'b0, nm);         // already present
        nm = {8'hFF};
        push_name(OP_INTERN, 1'b1, nm);         // active single character
        nm = {8'h41, 8'h42};
        push_name(OP_FIND, 1'b1, nm);           // active but two bytes
        nm = {};
        push_name(OP_INTERN, 1'b1, nm);         // active and empty
        push_req(OP_INTERN, 1'b0, 1'b1, 8'h55, 1'b0, '0);
        push_read(10'd2);                       // read in the middle of a name
        push_req(OP_INTERN, 1'b0, 1'b0, 8'hAA, 1'b0, '0);  // no byte carried
        push_req(OP_INTERN, 1'b0, 1'b1, 8'hAA, 1'b1, '0);
        push_req(OP_FIND, 1'b0, 1'b1, 8'h55, 1'b0, '0);
        push_req(OP_BAD, 1'b0, 1'b1, 8'h12, 1'b0, '0);     // discards the pending byte
        push_read(10'd0);
        push_read(10'h3FF);
        push_read(10'd4);
        nm = {};
        for (int i = 0; i < NAME_MAX; i++)
            nm.push_back(8'($urandom));
        push_name(OP_INTERN, 1'b0, nm);         // longest legal name
        push_read(10'd5);
        nm.push_back(8'h7E);
        push_name(OP_INTERN, 1'b0, nm);         // one byte too long

        // Once the directed requests are all sent, hold the sender until every
        // response they cause has come back.
        while (request_q.size() > 0 || req.valid)
            @(posedge clk);
        send_hold = 1'b1;
        wait_drained();
        send_hold = 1'b0;

        // Random part: short names drawn mostly from a small alphabet so that
        // lookups hit earlier entries, with reads and invalid codes mixed in.
        // The middle stretch runs without idling.
        for (int i = 0; i < 4; i++)
            pool[i] = 8'($urandom);
        sent = 0;
        while (sent < 25)
        begin
            if (sent > 8 && sent < 18)
                idle_pct = 0;
            else
                idle_pct = 14;
            pick = $urandom_range(0, 99);
            if (pick < 20)
            begin
                push_read(($urandom_range(0, 3) == 0) ? 10'($urandom)
                                                      : 10'($urandom_range(0, tbl_count + 12)));
                sent++;
            end
            else if (pick < 24)
            begin
                push_req(OP_BAD, 1'($urandom), 1'($urandom), 8'($urandom), 1'($urandom),
                         10'($urandom));
                sent++;
            end
            else
            begin
                op  = ($urandom_range(0, 1) == 0) ? OP_FIND : OP_INTERN;
                len = $urandom_range(0, 4);
                knd = ($urandom_range(0, 4) == 0);
                if (knd && $urandom_range(0, 3) != 0)
                    len = 1;
                nm = {};
                for (int i = 0; i < len; i++)
                    nm.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                             : pool[$urandom_range(0, 3)]);
                if (len > 1 && $urandom_range(0, 5) == 0)
                    push_req(op, 1'($urandom), 1'b0, 8'($urandom), 1'b0, 10'($urandom));
                push_name(op, knd, nm);
                sent += (len == 0) ? 1 : len;
            end
            while (request_q.size() > 8)
                @(posedge clk);
        end
        idle_pct = 14;
        wait_drained();
        repeat (300) @(posedge clk);

        $display("covered %0d responses: %0d names interned, %0d lookup hits, %0d name reads",
                 checked, interned, hits, reads_ok);
        $display("table ended with %0d entries and %0d arena bytes", tbl_count, arena_used);
        if (fail_count == 0 && response_q.size() == 0)
            $display("symbol_intern_hash_table regression: pass");
        else
            $display("symbol_intern_hash_table regression: fail");
        $finish;
    end

endmodule
